@@ hdl/mqttcd_pkg.sv @@
// ----------------------------------------------------------------------------
// mqttcd_pkg
// Shared constants and types for the MQTT CONNACK stream deframer.
// ----------------------------------------------------------------------------
package mqttcd_pkg;

   // longest remaining-length field, in 7-bit groups (1 to 4)
   localparam int MAX_LENGTH_GROUPS = 4;

   localparam int LEFT_BITS  = 28;
   localparam int GROUP_BITS = 7;

   localparam logic [3:0] CONNACK_TYPE = 4'd2;

   localparam logic [1:0] EV_CONNECTED    = 2'd0;
   localparam logic [1:0] EV_REFUSED      = 2'd1;
   localparam logic [1:0] EV_DISCONNECTED = 2'd2;
   localparam logic [1:0] EV_MALFORMED    = 2'd3;

   localparam logic FUNC_BYTE      = 1'b0;
   localparam logic FUNC_LINK_DOWN = 1'b1;

   typedef struct packed {
      logic       hit;
      logic [1:0] ev;
      logic [7:0] return_code;
      logic       return_code_valid;
   } result_type;

endpackage

@@ hdl/mqttcd_framer.sv @@
// ----------------------------------------------------------------------------
// mqttcd_framer
// Framing state and the per-word update: header, length field, body skip and
// CONNACK outcome. The result for a word is combinational from the state.
// ----------------------------------------------------------------------------
module mqttcd_framer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_i,
   input  logic                   func_i,
   input  logic [7:0]             rx_byte_i,
   output mqttcd_pkg::result_type res_o
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   phase_type                           phase_ff, phase_in;
   logic [3:0]                          type_ff, type_in;
   logic [mqttcd_pkg::LEFT_BITS-1:0]    left_ff, left_in;
   logic [2:0]                          count_ff, count_in;
   logic [1:0]                          seen_ff, seen_in;
   logic [7:0]                          ack_ff, ack_in;
   logic                                link_ff, link_in;
   logic                                stuck_ff, stuck_in;

   logic                                fin;
   logic [mqttcd_pkg::LEFT_BITS-1:0]    group_sh;
   logic [mqttcd_pkg::GROUP_BITS-1:0]   group;

   assign group = rx_byte_i[mqttcd_pkg::GROUP_BITS-1:0];

   // least significant group first
   always_comb begin
      unique case (count_ff[1:0])
         2'd0:    group_sh = mqttcd_pkg::LEFT_BITS'(group);
         2'd1:    group_sh = mqttcd_pkg::LEFT_BITS'(group) << mqttcd_pkg::GROUP_BITS;
         2'd2:    group_sh = mqttcd_pkg::LEFT_BITS'(group) << (2 * mqttcd_pkg::GROUP_BITS);
         default: group_sh = mqttcd_pkg::LEFT_BITS'(group) << (3 * mqttcd_pkg::GROUP_BITS);
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      left_in  = left_ff;
      count_in = count_ff;
      seen_in  = seen_ff;
      ack_in   = ack_ff;
      link_in  = link_ff;
      stuck_in = stuck_ff;
      res_o    = '0;
      fin      = 1'b0;
      if (step_i) begin
         if (func_i == mqttcd_pkg::FUNC_LINK_DOWN) begin
            phase_in = PH_HEADER;
            type_in  = '0;
            left_in  = '0;
            count_in = '0;
            seen_in  = '0;
            ack_in   = '0;
            link_in  = 1'b0;
            stuck_in = 1'b0;
            if (link_ff) begin
               res_o.hit = 1'b1;
               res_o.ev  = mqttcd_pkg::EV_DISCONNECTED;
            end
         end else if (!stuck_ff) begin
            unique case (phase_ff)
               PH_LENGTH: begin
                  left_in  = left_ff + group_sh;
                  count_in = count_ff + 3'd1;
                  if (rx_byte_i[7]) begin
                     if (count_in >= 3'(mqttcd_pkg::MAX_LENGTH_GROUPS)) begin
                        stuck_in  = 1'b1;
                        res_o.hit = 1'b1;
                        res_o.ev  = mqttcd_pkg::EV_MALFORMED;
                     end
                  end else if (left_in == '0) begin
                     fin = 1'b1;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
               PH_BODY: begin
                  if (seen_ff == 2'd1) begin
                     ack_in = rx_byte_i;
                  end
                  if (seen_ff != 2'd3) begin
                     seen_in = seen_ff + 2'd1;
                  end
                  left_in = left_ff - mqttcd_pkg::LEFT_BITS'(1);
                  fin     = (left_in == '0);
               end
               default: begin
                  // header byte; the unused phase code lands here as well
                  phase_in = PH_LENGTH;
                  type_in  = rx_byte_i[7:4];
                  left_in  = '0;
                  count_in = '0;
                  seen_in  = '0;
                  ack_in   = '0;
               end
            endcase
            if (fin) begin
               if (type_in == mqttcd_pkg::CONNACK_TYPE) begin
                  if (seen_in == 2'd2 && ack_in == 8'd0) begin
                     if (!link_ff) begin
                        link_in   = 1'b1;
                        res_o.hit = 1'b1;
                        res_o.ev  = mqttcd_pkg::EV_CONNECTED;
                     end
                  end else begin
                     res_o.hit = 1'b1;
                     res_o.ev  = mqttcd_pkg::EV_REFUSED;
                     if (seen_in >= 2'd2) begin
                        res_o.return_code       = ack_in;
                        res_o.return_code_valid = 1'b1;
                     end
                  end
               end
               phase_in = PH_HEADER;
               type_in  = '0;
               left_in  = '0;
               count_in = '0;
               seen_in  = '0;
               ack_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         type_ff  <= '0;
         left_ff  <= '0;
         count_ff <= '0;
         seen_ff  <= '0;
         ack_ff   <= '0;
         link_ff  <= 1'b0;
         stuck_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         left_ff  <= left_in;
         count_ff <= count_in;
         seen_ff  <= seen_in;
         ack_ff   <= ack_in;
         link_ff  <= link_in;
         stuck_ff <= stuck_in;
      end
   end

   // once stuck, only a link-down word clears it
   a_stuck_holds: assert property (@(posedge clock) disable iff (reset)
      stuck_ff && !(step_i && func_i == mqttcd_pkg::FUNC_LINK_DOWN) |=> stuck_ff)
      else $error("stuck flag dropped without link-down");

   // a connected report needs the link to have been down
   a_connect_once: assert property (@(posedge clock) disable iff (reset)
      res_o.hit && res_o.ev == mqttcd_pkg::EV_CONNECTED |-> !link_ff)
      else $error("connected reported while already connected");

   // body phase always has bytes still to skip
   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> left_ff != '0)
      else $error("body phase with nothing left to skip");

endmodule

@@ hdl/mqtt_connack_stream_deframer.sv @@
// ----------------------------------------------------------------------------
// mqtt_connack_stream_deframer
// Frames a received MQTT byte stream and reports CONNACK outcomes and link loss.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one word per received byte (req_func = 0, req_rx_byte) or a
//   link-down notice (req_func = 1). A word is taken when req_valid is high and
//   req_stall is low.
//   rsp_ channel: zero or one result word per request word: connected, refused
//   (with return code when the body carried one), disconnected or malformed
//   length field. Taken when rsp_valid is high and rsp_stall is low.
//   Timing: a taken word is held in the input register, and its result is
//   loaded into the result register when the word advances through the
//   framing update. Words that produce no result vanish silently.
//   Throughput: one word per cycle while the result register is not held
//   by rsp_stall.
//   Stall: while a result waits under rsp_stall, the input register still
//   takes a word; req_stall rises only when both registers are occupied.
//   Reset: synchronous, clears the framing state, the connected flag, the
//   malformed flag and both valid registers.
// ----------------------------------------------------------------------------
module mqtt_connack_stream_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_res,
   output logic [7:0] rsp_return_code,
   output logic       rsp_return_code_valid
);

   logic                   in_valid_ff, in_valid_in;
   logic                   in_func_ff;
   logic [7:0]             in_byte_ff;
   logic                   out_valid_ff, out_valid_in;
   mqttcd_pkg::result_type out_ff;
   mqttcd_pkg::result_type res;
   logic                   adv;
   logic                   take;

   assign adv       = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !adv;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !adv);
   assign out_valid_in = (adv && res.hit) || (out_valid_ff && rsp_stall);

   mqttcd_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .step_i    (adv),
      .func_i    (in_func_ff),
      .rx_byte_i (in_byte_ff),
      .res_o     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (take) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_rx_byte;
      end
      if (adv && res.hit) begin
         out_ff <= res;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_event_res         = out_ff.ev;
   assign rsp_return_code       = out_ff.return_code;
   assign rsp_return_code_valid = out_ff.return_code_valid;

   // a return code only travels with a refusal
   a_rc_refused: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.return_code_valid |-> out_ff.ev == mqttcd_pkg::EV_REFUSED)
      else $error("return code flagged on a non-refused result");

   // return code is zero unless flagged
   a_rc_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.return_code_valid |-> out_ff.return_code == 8'd0)
      else $error("stray return code");

   // a stalled input word implies a blocked result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled without a blocked result");

endmodule

@@ tb/tb_mqtt_connack_stream_deframer.sv @@
// ----------------------------------------------------------------------------
// tb_mqtt_connack_stream_deframer
// Self-checking bench for the MQTT CONNACK stream deframer. A short table of
// hand-written words is followed by randomly built packet streams (CONNACKs,
// other packets, padded length fields, overlong length fields, abandoned
// packets and link-down notices). Every accepted word is run through a local
// framing model, and each result word is checked field by field, in order.
// The request channel idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module tb_mqtt_connack_stream_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 650;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef struct packed {
      logic                   func;
      logic [7:0]             data;
      logic                   fixed;   // expected outcome typed into the table
      mqttcd_pkg::result_type want;
   } plan_row_type;

   localparam mqttcd_pkg::result_type NO_RESULT = '0;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_func;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_event_res;
   logic [7:0] rsp_return_code;
   logic       rsp_return_code_valid;

   plan_row_type           plan[$];
   mqttcd_pkg::result_type pending_events[$];
   mqttcd_pkg::result_type head;
   int                     errors = 0;
   int                     cycles = 0;
   int                     send_quiet = 0;
   int                     take_quiet = 0;

   // framing model state
   phase_type   rx_phase;
   logic [3:0]  rx_type;
   logic [27:0] rx_left;
   logic [2:0]  rx_groups;
   logic [1:0]  rx_body;
   logic [7:0]  rx_code;
   logic        rx_linked;
   logic        rx_stuck;

   mqtt_connack_stream_deframer i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_func              (req_func),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_event_res         (rsp_event_res),
      .rsp_return_code       (rsp_return_code),
      .rsp_return_code_valid (rsp_return_code_valid)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic mqttcd_pkg::result_type outcome(input logic [1:0] ev,
                                                      input logic [7:0] rc,
                                                      input logic rcv);
      return {1'b1, ev, rc, rcv};
   endfunction

   task automatic add_row(input logic f, input logic [7:0] d, input logic fixed,
                          input mqttcd_pkg::result_type want);
      plan.push_back({f, d, fixed, want});
   endtask

   task automatic draw_gap(inout int quiet, output int gap);
      if (quiet > 0) begin
         quiet--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 19) == 0) quiet = $urandom_range(8, 40);
         gap = $urandom_range(0, 12);
      end
   endtask

   function automatic void clear_framing();
      rx_phase  = PH_HEADER;
      rx_type   = 4'd0;
      rx_left   = '0;
      rx_groups = 3'd0;
      rx_body   = 2'd0;
      rx_code   = 8'd0;
   endfunction

   function automatic mqttcd_pkg::result_type close_packet();
      mqttcd_pkg::result_type r;
      r = NO_RESULT;
      if (rx_type == mqttcd_pkg::CONNACK_TYPE) begin
         if (rx_body == 2'd2 && rx_code == 8'd0) begin
            if (!rx_linked) begin
               rx_linked = 1'b1;
               r = outcome(mqttcd_pkg::EV_CONNECTED, 8'h00, 1'b0);
            end
         end else if (rx_body >= 2'd2) begin
            r = outcome(mqttcd_pkg::EV_REFUSED, rx_code, 1'b1);
         end else begin
            r = outcome(mqttcd_pkg::EV_REFUSED, 8'h00, 1'b0);
         end
      end
      clear_framing();
      return r;
   endfunction

   // one accepted word through the framing model
   function automatic mqttcd_pkg::result_type deframe_step(input logic f,
                                                           input logic [7:0] b);
      mqttcd_pkg::result_type r;
      logic                   was_linked;
      int                     shift;
      r = NO_RESULT;
      if (f == mqttcd_pkg::FUNC_LINK_DOWN) begin
         was_linked = rx_linked;
         clear_framing();
         rx_linked = 1'b0;
         rx_stuck  = 1'b0;
         if (was_linked) r = outcome(mqttcd_pkg::EV_DISCONNECTED, 8'h00, 1'b0);
         return r;
      end
      if (rx_stuck) return r;
      case (rx_phase)
         PH_LENGTH: begin
            shift     = 7 * rx_groups[1:0];
            rx_left   = rx_left + ({21'd0, b[6:0]} << shift);
            rx_groups = rx_groups + 3'd1;
            if (b[7]) begin
               if (rx_groups >= mqttcd_pkg::MAX_LENGTH_GROUPS) begin
                  rx_stuck = 1'b1;
                  r = outcome(mqttcd_pkg::EV_MALFORMED, 8'h00, 1'b0);
               end
            end else if (rx_left == '0) begin
               r = close_packet();
            end else begin
               rx_phase = PH_BODY;
            end
         end
         PH_BODY: begin
            if (rx_body == 2'd1) rx_code = b;
            if (rx_body < 2'd3) rx_body = rx_body + 2'd1;
            rx_left = rx_left - 28'd1;
            if (rx_left == '0) r = close_packet();
         end
         default: begin
            // phase 3 never occurs; treated as awaiting a header
            clear_framing();
            rx_type  = b[7:4];
            rx_phase = PH_LENGTH;
         end
      endcase
      return r;
   endfunction

   // result channel: stall pattern
   initial begin
      int gap;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         draw_gap(take_quiet, gap);
         repeat (gap) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got event %0d rc %0h rcv %0d",
                     $time, rsp_event_res, rsp_return_code, rsp_return_code_valid);
            errors++;
         end else begin
            head = pending_events.pop_front();
            if (rsp_event_res !== head.ev) begin
               $display("%0t: event_res expected %0d got %0d", $time, head.ev, rsp_event_res);
               errors++;
            end
            if (rsp_return_code !== head.return_code) begin
               $display("%0t: return_code expected %0h got %0h", $time, head.return_code,
                        rsp_return_code);
               errors++;
            end
            if (rsp_return_code_valid !== head.return_code_valid) begin
               $display("%0t: return_code_valid expected %0d got %0d", $time,
                        head.return_code_valid, rsp_return_code_valid);
               errors++;
            end
         end
      end
   end

   initial begin
      int                     pick;
      int                     len;
      int                     ng;
      int                     least;
      int                     g;
      int                     gap;
      int                     n_directed;
      logic [3:0]             ptype;
      logic [7:0]             byte_v;
      mqttcd_pkg::result_type got;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_func    = mqttcd_pkg::FUNC_BYTE;
      req_rx_byte = 8'h00;
      clear_framing();
      rx_linked = 1'b0;
      rx_stuck  = 1'b0;

      // directed words
      // link down straight after reset
      add_row(mqttcd_pkg::FUNC_LINK_DOWN, 8'h00, 1'b1, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h20, 1'b1, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h02, 1'b1, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'hFF, 1'b1, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h00, 1'b1,
              outcome(mqttcd_pkg::EV_CONNECTED, 8'h00, 1'b0));
      // refused, two-byte body
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h20, 1'b1, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h02, 1'b1, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h00, 1'b1, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h86, 1'b1,
              outcome(mqttcd_pkg::EV_REFUSED, 8'h86, 1'b1));
      // accepted while connected
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h2F, 1'b0, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h02, 1'b0, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h00, 1'b0, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h00, 1'b0, NO_RESULT);
      // empty body
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h20, 1'b1, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h00, 1'b1,
              outcome(mqttcd_pkg::EV_REFUSED, 8'h00, 1'b0));
      // largest length, then abandoned
      add_row(mqttcd_pkg::FUNC_BYTE, 8'hF0, 1'b0, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'hFF, 1'b0, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'hFF, 1'b0, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'hFF, 1'b0, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h7F, 1'b0, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_LINK_DOWN, 8'hA5, 1'b1,
              outcome(mqttcd_pkg::EV_DISCONNECTED, 8'h00, 1'b0));
      // overlong length field
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h10, 1'b0, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h80, 1'b0, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h80, 1'b0, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h80, 1'b0, NO_RESULT);
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h80, 1'b1,
              outcome(mqttcd_pkg::EV_MALFORMED, 8'h00, 1'b0));
      // ignored while stuck
      add_row(mqttcd_pkg::FUNC_BYTE, 8'h20, 1'b1, NO_RESULT);
      n_directed = plan.size();

      // random packet streams
      while (plan.size() < n_directed + RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            add_row(mqttcd_pkg::FUNC_LINK_DOWN, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
         end else if (pick < 14) begin
            add_row(mqttcd_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
         end else if (pick < 17) begin
            // overlong length field, a few ignored words, then link down
            add_row(mqttcd_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
            for (g = 0; g < mqttcd_pkg::MAX_LENGTH_GROUPS; g++)
               add_row(mqttcd_pkg::FUNC_BYTE, 8'h80 | 8'($urandom_range(0, 127)), 1'b0,
                       NO_RESULT);
            repeat ($urandom_range(0, 4))
               add_row(mqttcd_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
            add_row(mqttcd_pkg::FUNC_LINK_DOWN, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
         end else if (pick < 21) begin
            // huge length, packet cut short by link down
            add_row(mqttcd_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
            for (g = 0; g < 3; g++)
               add_row(mqttcd_pkg::FUNC_BYTE, 8'h80 | 8'($urandom_range(0, 127)), 1'b0,
                       NO_RESULT);
            add_row(mqttcd_pkg::FUNC_BYTE, 8'($urandom_range(1, 127)), 1'b0, NO_RESULT);
            repeat ($urandom_range(0, 3))
               add_row(mqttcd_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
            add_row(mqttcd_pkg::FUNC_LINK_DOWN, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
         end else begin
            ptype = (pick < 60) ? mqttcd_pkg::CONNACK_TYPE : 4'($urandom_range(0, 15));
            add_row(mqttcd_pkg::FUNC_BYTE, {ptype, 4'($urandom_range(0, 15))}, 1'b0,
                    NO_RESULT);
            pick = $urandom_range(0, 99);
            if (pick < 45)      len = 2;
            else if (pick < 90) len = $urandom_range(0, 6);
            else if (pick < 97) len = $urandom_range(7, 40);
            else                len = $urandom_range(100, 300);
            least = (len < 128) ? 1 : 2;
            // padded encodings now and then
            ng = ($urandom_range(0, 3) == 0) ?
                 $urandom_range(least, mqttcd_pkg::MAX_LENGTH_GROUPS) : least;
            for (g = 0; g < ng; g++) begin
               byte_v = 8'((len >> (7 * g)) & 127);
               if (g < ng - 1) byte_v = byte_v | 8'h80;
               add_row(mqttcd_pkg::FUNC_BYTE, byte_v, 1'b0, NO_RESULT);
            end
            for (g = 0; g < len; g++) begin
               if (g == 1 && ptype == mqttcd_pkg::CONNACK_TYPE && $urandom_range(0, 9) < 6)
                  byte_v = 8'h00;
               else
                  byte_v = 8'($urandom_range(0, 255));
               add_row(mqttcd_pkg::FUNC_BYTE, byte_v, 1'b0, NO_RESULT);
            end
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         draw_gap(send_quiet, gap);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         @(negedge clock);
         req_valid   <= 1'b1;
         req_func    <= plan[k].func;
         req_rx_byte <= plan[k].data;
         do @(posedge clock); while (req_stall);
         got = deframe_step(plan[k].func, plan[k].data);
         if (plan[k].fixed) got = plan[k].want;
         if (got.hit) pending_events.push_back(got);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
